// ===== sv/cipdr_pkg.sv =====
`default_nettype none

package cipdr_pkg;

  localparam int unsigned DutyW    = 7;
  localparam int unsigned VbusW    = 14;
  localparam int unsigned IbatW    = 16;
  localparam int unsigned EstW     = 12;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  localparam logic [DutyW-1:0] BeginOffset    = 7'd90;
  localparam logic [DutyW-1:0] MaxStartDuty   = 7'd96;
  localparam logic [DutyW-1:0] OcMargin       = 7'd15;
  localparam logic [DutyW-1:0] StepDown       = 7'd3;
  localparam logic [DutyW-1:0] StepUp         = 7'd5;
  localparam logic [DutyW-1:0] StepFastDown   = 7'd15;
  localparam logic [DutyW-1:0] DutyFull       = 7'd100;
  localparam logic [DutyW-1:0] LightLimitDuty = 7'd90;
  localparam logic [EstW-1:0]  MapA           = 12'd3012;
  localparam logic [EstW-1:0]  MapBMag        = 12'd29;

  localparam logic [VbusW-1:0] VbusHighRst      = 14'd4700;
  localparam logic [VbusW-1:0] VbusHighLightRst = 14'd4550;
  localparam logic [VbusW-1:0] VbusLowRst       = 14'd4500;
  localparam logic [VbusW-1:0] VbusHardLowRst   = 14'd4400;
  localparam logic [7:0]       OverrideRst      = 8'hFF;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_NOMINAL = 2'd1,
    REQ_FLOOR   = 2'd2,
    REQ_RELEASE = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AGGRESSIVE = 3'd0,
    CFG_OVERRIDE   = 3'd1,
    CFG_VBUS_HIGH  = 3'd2,
    CFG_VBUS_LIGHT = 3'd3,
    CFG_VBUS_LOW   = 3'd4,
    CFG_VBUS_HARD  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic              aggressive;
    logic signed [7:0] override;
    logic [VbusW-1:0]  vbus_high;
    logic [VbusW-1:0]  vbus_light;
    logic [VbusW-1:0]  vbus_low;
    logic [VbusW-1:0]  vbus_hard_low;
  } cfg_t;

  typedef struct packed {
    req_e              req_type;
    logic [VbusW-1:0]  vbus_mv;
    logic signed [IbatW-1:0] battery_ma;
    logic              battery_read_error;
    logic [DutyW-1:0]  value;
  } item_t;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic [DutyW-1:0] nominal;
    logic             fast_mode;
    logic [DutyW-1:0] floor_duty;
    logic             pwm_on;
  } state_t;

  typedef struct packed {
    logic [EstW-1:0]  current_estimate_ma;
    logic             duty_changed;
    logic             pwm_active;
    logic [DutyW-1:0] duty_percent;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/cipdr_core.sv =====
`default_nettype none

module cipdr_core import cipdr_pkg::*; (
  input  var cfg_t    cfg_i,
  input  var state_t  state_i,
  input  var item_t   item_i,
  output var state_t  state_o,
  output var result_t result_o
);

  logic signed [8:0] duty_s, nom_lo_s, floor_s, fast_s, slow_s;
  logic [DutyW-1:0]  forced, up_duty, start_duty, lower_duty;
  logic              is_low, is_high, can_lower, changed;
  logic [EstW-1:0]   est;

  always_comb begin
    duty_s   = signed'({2'b00, state_i.duty});
    nom_lo_s = signed'({2'b00, state_i.nominal}) - signed'({2'b00, OcMargin});
    floor_s  = signed'({2'b00, state_i.floor_duty});
    fast_s   = duty_s - signed'({2'b00, StepFastDown});
    slow_s   = duty_s - signed'({2'b00, StepDown});

    forced = (cfg_i.override > signed'({1'b0, DutyFull})) ? DutyFull
                                                         : cfg_i.override[DutyW-1:0];
    up_duty = (state_i.duty > DutyFull - StepUp) ? DutyFull : state_i.duty + StepUp;

    if (item_i.battery_read_error) begin
      start_duty = (item_i.value > DutyFull) ? DutyFull : item_i.value;
    end else if (item_i.value > MaxStartDuty - BeginOffset) begin
      start_duty = MaxStartDuty;
    end else begin
      start_duty = item_i.value + BeginOffset;
    end

    // low / high vbus decisions
    if (item_i.battery_ma[IbatW-1]) begin
      is_low = (item_i.vbus_mv < cfg_i.vbus_hard_low) && (state_i.duty < DutyFull);
    end else begin
      is_low = (item_i.vbus_mv < cfg_i.vbus_low) && (state_i.duty < DutyFull);
    end
    is_high = (item_i.vbus_mv > cfg_i.vbus_high) ||
              ((item_i.vbus_mv > cfg_i.vbus_light) && (state_i.duty > LightLimitDuty));

    // next lower duty
    can_lower  = 1'b0;
    lower_duty = state_i.duty;
    if (cfg_i.aggressive) begin
      if (state_i.fast_mode && (fast_s >= nom_lo_s) && (fast_s >= floor_s)) begin
        can_lower  = 1'b1;
        lower_duty = fast_s[8] ? '0 : fast_s[DutyW-1:0];
      end else if ((duty_s > nom_lo_s) && (duty_s > floor_s) && (state_i.duty != '0)) begin
        can_lower  = 1'b1;
        lower_duty = slow_s[8] ? '0 : slow_s[DutyW-1:0];
      end
    end else if ((state_i.duty > state_i.nominal) && (state_i.duty != '0)) begin
      can_lower  = 1'b1;
      lower_duty = slow_s[8] ? '0 : slow_s[DutyW-1:0];
    end

    state_o = state_i;
    changed = 1'b0;
    case (item_i.req_type)
      REQ_TICK: begin
        if (state_i.pwm_on && !item_i.battery_read_error) begin
          if (!cfg_i.override[7]) begin
            if (forced != state_i.duty) begin
              state_o.duty = forced;
              changed      = 1'b1;
            end
          end else if (is_low) begin
            state_o.duty      = up_duty;
            state_o.fast_mode = 1'b0;
            changed           = 1'b1;
          end else if (is_high && can_lower) begin
            state_o.duty = lower_duty;
            changed      = 1'b1;
          end
        end
      end
      REQ_NOMINAL: begin
        state_o.duty      = start_duty;
        state_o.nominal   = item_i.value;
        state_o.fast_mode = 1'b1;
        state_o.pwm_on    = 1'b1;
        changed           = 1'b1;
      end
      REQ_FLOOR: begin
        state_o.floor_duty = item_i.value;
      end
      default: begin
        state_o.pwm_on = 1'b0;
      end
    endcase

    est = MapA - EstW'({5'b0, state_o.duty} * MapBMag);

    result_o.duty_percent        = state_o.duty;
    result_o.pwm_active          = state_o.pwm_on;
    result_o.duty_changed        = changed;
    result_o.current_estimate_ma = est;
  end

endmodule

`default_nettype wire

// ===== sv/charge_input_pwm_duty_regulator.sv =====
// Input current limit PWM duty regulator. Each input beat is a tick (VBUS sample, battery
// current, read-error flag), a set-nominal, a set-over-current-floor or a release-to-manual
// request; every beat gives exactly one result beat with the duty after that beat, the PWM
// enable, whether the duty was rewritten and the estimated current limit (3012 - 29 * duty).
// Beats are registered on entry, pass through one stage of compare-and-step logic and land
// in an output register, so the block takes one beat per clock unless the output stalls;
// the input register may take the next beat while a result still waits, if it is empty.
// Users must write configuration registers via cfg_we_i only while idle (not enforced).
`default_nettype none

module charge_input_pwm_duty_regulator import cipdr_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  // vbus_mv, battery_ma, battery_read_error, value, zero pad
  input  wire [InDataW-1:0]   s_axis_tdata,
  // req_type
  input  wire [1:0]           s_axis_tuser,
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  // duty_percent, pwm_active, duty_changed, current_estimate_ma, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgDataW-1:0]  cfg_wdata_i
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item_q, item_in;
  result_t res_q, res_d;
  logic    in_valid_q, out_valid_q, advance;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    item_in.req_type           = req_e'(s_axis_tuser);
    item_in.vbus_mv            = s_axis_tdata[13:0];
    item_in.battery_ma         = signed'(s_axis_tdata[29:14]);
    item_in.battery_read_error = s_axis_tdata[30];
    item_in.value              = s_axis_tdata[37:31];
  end

  cipdr_core u_core (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.aggressive    <= 1'b1;
      cfg_q.override      <= signed'(OverrideRst);
      cfg_q.vbus_high     <= VbusHighRst;
      cfg_q.vbus_light    <= VbusHighLightRst;
      cfg_q.vbus_low      <= VbusLowRst;
      cfg_q.vbus_hard_low <= VbusHardLowRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_AGGRESSIVE: cfg_q.aggressive    <= cfg_wdata_i[0];
        CFG_OVERRIDE:   cfg_q.override      <= signed'(cfg_wdata_i[7:0]);
        CFG_VBUS_HIGH:  cfg_q.vbus_high     <= cfg_wdata_i;
        CFG_VBUS_LIGHT: cfg_q.vbus_light    <= cfg_wdata_i;
        CFG_VBUS_LOW:   cfg_q.vbus_low      <= cfg_wdata_i;
        CFG_VBUS_HARD:  cfg_q.vbus_hard_low <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
        if (in_valid_q) begin
          state_q <= state_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_in;
    end
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q};

endmodule

`default_nettype wire

// ===== sv/cipdr_checker.sv =====
`default_nettype none

module cipdr_checker import cipdr_pkg::*; (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                s_axis_tvalid,
  input wire                s_axis_tready,
  input wire                m_axis_tvalid,
  input wire                m_axis_tready,
  input wire [OutDataW-1:0] m_axis_tdata
);

  // duty stays in range on every result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[6:0] <= DutyFull))
    else $error("duty above full scale");

  // estimate follows the reported duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[20:9] == MapA - EstW'({5'b0, m_axis_tdata[6:0]} * MapBMag)))
    else $error("current estimate does not match duty");

  // manual mode never rewrites the duty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[7]) |-> !m_axis_tdata[8])
    else $error("duty changed while in manual mode");

  // an accepted input beat shows up as a result after the input and output registers when nothing stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result beat missing");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat changed under stall");

endmodule

bind charge_input_pwm_duty_regulator cipdr_checker u_cipdr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
